// ===== sv/assert_macros.svh =====
// Assertion helper macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ramr_pkg.sv =====
// ----------------------------------------------------------------------------
// ramr_pkg
// Shared types and constants for the fraction add/multiply reduction block.
// ----------------------------------------------------------------------------
`default_nettype none
package ramr_pkg;
    localparam int NUM_WIDTH = 63;
    localparam int DEN_WIDTH = 62;
    localparam int WORK_WIDTH = 64;
    localparam int STEP_WIDTH = 7;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL1 = 9'b000000010,
        ST_MUL2 = 9'b000000100,
        ST_MUL3 = 9'b000001000,
        ST_SUM  = 9'b000010000,
        ST_GCD  = 9'b000100000,
        ST_DIVN = 9'b001000000,
        ST_DIVD = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;
endpackage
`default_nettype wire

// ===== sv/ramr_divider.sv =====
// ----------------------------------------------------------------------------
// ramr_divider
// Restoring radix-2 divider for 64-bit unsigned values, one quotient bit
// per cycle. Division by zero gives quotient all ones and remainder equal
// to the dividend.
// ----------------------------------------------------------------------------
`default_nettype none
module ramr_divider
    import ramr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [WORK_WIDTH-1:0] dividend,
    input  wire logic [WORK_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [WORK_WIDTH-1:0]      quotient,
    output logic [WORK_WIDTH-1:0]      remainder
);
    logic                    busy_reg;
    logic [STEP_WIDTH-1:0]   count_reg;
    logic [WORK_WIDTH-1:0]   quo_reg;
    logic [WORK_WIDTH-1:0]   rem_reg;
    logic [WORK_WIDTH-1:0]   dsr_reg;
    logic                    done_reg;
    logic [WORK_WIDTH:0]     shifted;
    logic [WORK_WIDTH:0]     diff;

    assign shifted = {rem_reg, quo_reg[WORK_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= STEP_WIDTH'(WORK_WIDTH);
                quo_reg   <= dividend;
                rem_reg   <= '0;
                dsr_reg   <= divisor;
            end else if (busy_reg) begin
                if (!diff[WORK_WIDTH]) begin
                    rem_reg <= diff[WORK_WIDTH-1:0];
                    quo_reg <= {quo_reg[WORK_WIDTH-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[WORK_WIDTH-1:0];
                    quo_reg <= {quo_reg[WORK_WIDTH-2:0], 1'b0};
                end
                count_reg <= count_reg - 1'b1;
                if (count_reg == STEP_WIDTH'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ===== sv/rational_add_mul_reduce_top.sv =====
// ----------------------------------------------------------------------------
// rational_add_mul_reduce_top
// Adds or multiplies two fractions and reduces the result by Euclid's GCD.
// ----------------------------------------------------------------------------
// One item is taken at a time. Two products (three for an add) go through
// one shared multiplier, then Euclid's loop runs on a shared 64-bit divider,
// each remainder step being one divider run with its start and done
// handshake, and two more divisions give the reduced numerator and
// denominator. Euclid's loop runs for up to about 90 remainder steps. A zero
// numerator gives 0/1; a zero over zero result gives 0/0.
`default_nettype none
`include "assert_macros.svh"
module rational_add_mul_reduce_top
    import ramr_pkg::*;
#(
    parameter int OPERAND_WIDTH = 31
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // Fields from bit 0: a_num, a_den, b_num, b_den (31 bits each), zero fill.
    input  wire logic [127:0]            s_tdata,
    // Field: operation.
    input  wire logic                    s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // Fields from bit 0: res_num (63 bits), res_den (62 bits), zero fill.
    output logic [127:0]                 m_tdata
);
    localparam int PROD_WIDTH = 2 * OPERAND_WIDTH;

    state_t                   state_reg;
    logic                     op_reg;
    logic [OPERAND_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [WORK_WIDTH-1:0]    rn_reg, rd_reg, tmp_reg, x_reg, y_reg, g_reg;
    logic [NUM_WIDTH-1:0]     out_num_reg;
    logic [DEN_WIDTH-1:0]     out_den_reg;
    logic                     div_start;
    logic [WORK_WIDTH-1:0]    div_a, div_b;
    logic                     div_done;
    logic [WORK_WIDTH-1:0]    div_q, div_r;
    logic [OPERAND_WIDTH-1:0] mul_a, mul_b;
    logic [PROD_WIDTH-1:0]    mul_p;

    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = ad_reg;
        mul_b = bd_reg;
        unique case (state_reg)
            ST_MUL2: begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            ST_MUL3: begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default: begin
            end
        endcase
    end

    ramr_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    logic start_reg;
    assign div_start = start_reg;

    always_comb begin
        div_a = x_reg;
        div_b = y_reg;
        unique case (state_reg)
            ST_DIVN: begin
                div_a = rn_reg;
                div_b = g_reg;
            end
            ST_DIVD: begin
                div_a = rd_reg;
                div_b = g_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser;
                        an_reg    <= s_tdata[OPERAND_WIDTH-1:0];
                        ad_reg    <= s_tdata[31 +: OPERAND_WIDTH];
                        bn_reg    <= s_tdata[62 +: OPERAND_WIDTH];
                        bd_reg    <= s_tdata[93 +: OPERAND_WIDTH];
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    rd_reg    <= WORK_WIDTH'(mul_p);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    rn_reg    <= WORK_WIDTH'(mul_p);
                    state_reg <= (op_reg == OP_MUL) ? ST_SUM : ST_MUL3;
                end
                ST_MUL3: begin
                    tmp_reg   <= WORK_WIDTH'(mul_p);
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    if (op_reg == OP_ADD) begin
                        rn_reg <= rn_reg + tmp_reg;
                        x_reg  <= rn_reg + tmp_reg;
                    end else begin
                        x_reg  <= rn_reg;
                    end
                    y_reg <= rd_reg;
                    if (rd_reg == '0) begin
                        // gcd(n, 0) = n; ST_GCD goes on to the divisions.
                        g_reg     <= (op_reg == OP_ADD) ? rn_reg + tmp_reg : rn_reg;
                        state_reg <= ST_GCD;
                    end else begin
                        start_reg <= 1'b1;
                        state_reg <= ST_GCD;
                    end
                end
                ST_GCD: begin
                    if (y_reg == '0) begin
                        g_reg     <= (x_reg == '0) ? WORK_WIDTH'(1) : x_reg;
                        start_reg <= 1'b1;
                        state_reg <= ST_DIVN;
                    end else if (div_done) begin
                        x_reg <= y_reg;
                        y_reg <= div_r;
                        if (div_r != '0) begin
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_DIVN: begin
                    if (div_done) begin
                        out_num_reg <= div_q[NUM_WIDTH-1:0];
                        start_reg   <= 1'b1;
                        state_reg   <= ST_DIVD;
                    end
                end
                ST_DIVD: begin
                    if (div_done) begin
                        out_den_reg <= div_q[DEN_WIDTH-1:0];
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {3'b0, out_den_reg, out_num_reg};

    `ASSERT_IMPL(a_one_side, aclk, aresetn, 1'b1, !(s_tready && m_tvalid), "both sides open")
    `ASSERT_NEXT(a_take, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_MUL1, "item lost")
    `ASSERT_IMPL(a_den_pos, aclk, aresetn, m_tvalid && (rd_reg != '0), out_den_reg != '0, "zero den")
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the fraction add/multiply reduction block. Each item
// gets a predicted reduced fraction, and each result is compared with the
// oldest prediction. Directed corner cases come first, then random fractions.
// ----------------------------------------------------------------------------
module testbench;
    import ramr_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // a_num, a_den, b_num, b_den (31 bits each), zero fill
    logic         s_tuser;   // operation
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // res_num (63 bits), res_den (62 bits), zero fill

    typedef struct packed {
        logic [NUM_WIDTH-1:0] num;
        logic [DEN_WIDTH-1:0] den;
    } fraction_t;

    fraction_t reduced_q[$];
    int        errors;
    bit        no_idle;
    bit        hold_off;
    int        quiet_cycles;

    rational_add_mul_reduce_top u_top (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic fraction_t reduce_fraction(logic op, logic [30:0] an, logic [30:0] ad,
                                                  logic [30:0] bn, logic [30:0] bd);
        logic [63:0] raw_num;
        logic [63:0] raw_den;
        logic [63:0] g;
        fraction_t   f;
        raw_den = 64'(ad) * 64'(bd);
        if (op == OP_ADD)
            raw_num = 64'(an) * 64'(bd) + 64'(bn) * 64'(ad);
        else
            raw_num = 64'(an) * 64'(bn);
        g = gcd64(raw_num, raw_den);
        if (g == 0) g = 1;
        f.num = NUM_WIDTH'(raw_num / g);
        f.den = DEN_WIDTH'(raw_den / g);
        return f;
    endfunction

    // Valid stays high after an accepted item until the next call either
    // offers a new item or idles, so valid is written once per time step.
    task automatic send_fraction_pair(logic op, logic [30:0] an, logic [30:0] ad,
                                      logic [30:0] bn, logic [30:0] bd);
        if (!no_idle) begin
            while ($urandom_range(99) < 26) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, bd, bn, ad, an};
        reduced_q.push_back(reduce_fraction(op, an, ad, bn, bd));
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [30:0] rand_operand();
        case ($urandom_range(4))
            0: return 31'($urandom_range(15));
            1: return 31'($urandom_range(1000));
            2: return 31'h7fffffff - 31'($urandom_range(3));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [30:0] m;
        m = 31'h7fffffff;
        for (int op = 0; op < 2; op++) begin
            send_fraction_pair(op, 0, 1, 0, 1);
            send_fraction_pair(op, m, m, m, m);
            send_fraction_pair(op, m, 1, m, 1);
            send_fraction_pair(op, 1, m, 1, m);
            send_fraction_pair(op, 0, 5, 3, 7);
            send_fraction_pair(op, 1, 2, 1, 2);
            send_fraction_pair(op, 31'h55555555, 31'h2aaaaaaa, 31'h2aaaaaaa, 31'h55555555);
            // Out-of-range zero denominators give 1/0 or zero over zero.
            send_fraction_pair(op, 3, 0, 4, 0);
            send_fraction_pair(op, 0, 0, 0, 0);
            send_fraction_pair(op, 5, 0, 0, 7);
        end
        // Consecutive Fibonacci values give long Euclid loops.
        send_fraction_pair(OP_MUL, 1134903170, 1836311903, 1, 1);
        send_fraction_pair(OP_ADD, 701408733, 1134903170, 0, 1);
    endtask

    task automatic test_random(int count);
        logic [30:0] ad;
        logic [30:0] bd;
        for (int i = 0; i < count; i++) begin
            ad = rand_operand();
            bd = rand_operand();
            if (ad == 0) ad = 1;
            if (bd == 0) bd = 1;
            send_fraction_pair(1'($urandom_range(1)), rand_operand(), ad, rand_operand(), bd);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(6);
        join
    endtask

    task automatic test_no_idle();
        no_idle = 1'b1;
        test_random(40);
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, checked against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reduced_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    errors++;
                end else begin
                    fraction_t f;
                    f = reduced_q.pop_front();
                    if (m_tdata[62:0] !== f.num) begin
                        $display("%0t: res_num expected %0d actual %0d",
                                 $time, f.num, m_tdata[62:0]);
                        errors++;
                    end
                    if (m_tdata[124:63] !== f.den) begin
                        $display("%0t: res_den expected %0d actual %0d",
                                 $time, f.den, m_tdata[124:63]);
                        errors++;
                    end
                    if (m_tdata[127:125] !== 3'b0) begin
                        $display("%0t: fill bits expected 0 actual %b", $time, m_tdata[127:125]);
                        errors++;
                    end
                end
            end
            m_tready <= !hold_off && (no_idle || $urandom_range(99) >= 26);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 50000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        errors       = 0;
        no_idle      = 1'b0;
        hold_off     = 1'b0;
        quiet_cycles = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = 1'b0;
        s_tdata      = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_no_idle();
        test_random(380);
        s_tvalid <= 1'b0;
        while (reduced_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
